// ===== rtl/cpct_pkg.sv =====
package cpct_pkg;

  localparam int CUR_W = 16;
  localparam int OUT_W = CUR_W + 2;
  localparam int ANG_W = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TBL_N = 1 << SINE_TABLE_BITS;

  // square root unit: 44-bit radicand, 22-bit root, two root bits per stage
  localparam int SQ_IN_W = 44;
  localparam int ROOT_W = SQ_IN_W / 2;
  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int REM_W = SQ_IN_W + 2;

  // Q1.16 coefficients
  localparam logic signed [15:0] K_THIRD = 16'sd21845;
  localparam logic signed [17:0] K_INV_SQRT3 = 18'sd37837;
  localparam logic signed [17:0] K_TWO_INV_SQRT3 = 18'sd75674;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [16:0] sine_rom_t [0:TBL_N];

  // series term divided by (2n)(2n+1), evaluated while the table is built
  function automatic longint unsigned series_div(longint unsigned t, longint unsigned n);
    case (n)
      64'd1:   return t / 64'd6;
      64'd2:   return t / 64'd20;
      64'd3:   return t / 64'd42;
      64'd4:   return t / 64'd72;
      64'd5:   return t / 64'd110;
      64'd6:   return t / 64'd156;
      64'd7:   return t / 64'd210;
      64'd8:   return t / 64'd272;
      64'd9:   return t / 64'd342;
      64'd10:  return t / 64'd420;
      64'd11:  return t / 64'd506;
      64'd12:  return t / 64'd600;
      default: return t;
    endcase
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint sum;
    longint v;
    for (int k = 0; k <= TBL_N; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 12; n++) begin
        term = series_div((term * x2) >> 30, n);
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + (1 << 13)) >>> 14;
      if (v > 65536) v = 65536;
      r[k] = v[16:0];
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // quarter-wave lookup, no interpolation
  function automatic logic signed [17:0] sine_q16(logic [ANG_W-1:0] ang);
    logic [SINE_TABLE_BITS:0] idx;
    logic signed [17:0] v;
    idx = {1'b0, ang[13 -: SINE_TABLE_BITS]};
    if (ang[14]) idx = (SINE_TABLE_BITS+1)'(TBL_N) - idx;
    v = $signed({1'b0, SINE_ROM[idx]});
    if (ang[15]) v = -v;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [23:0] x);
    logic signed [23:0] hi;
    logic signed [23:0] lo;
    hi = 24'sd131071;
    lo = -24'sd131072;
    if (x > hi) return hi[OUT_W-1:0];
    if (x < lo) return lo[OUT_W-1:0];
    return x[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/cpct_sqrt.sv =====
module cpct_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_vld,
  input  logic [cpct_pkg::SQ_IN_W-1:0]    in_sq,
  output logic                            out_vld,
  output logic [cpct_pkg::ROOT_W-1:0]     out_root
);

  logic [cpct_pkg::REM_W-1:0]  rem_r  [0:cpct_pkg::SQRT_STAGES-1];
  logic [cpct_pkg::ROOT_W-1:0] root_r [0:cpct_pkg::SQRT_STAGES-1];
  logic                        vld_r  [0:cpct_pkg::SQRT_STAGES-1];

  genvar j;
  generate
    for (j = 0; j < cpct_pkg::SQRT_STAGES; j++) begin : g_stage
      localparam int KH = cpct_pkg::ROOT_W - 1 - 2 * j;
      logic [cpct_pkg::REM_W-1:0]  rem_in;
      logic [cpct_pkg::ROOT_W-1:0] root_in;
      logic                        vld_in;
      logic [cpct_pkg::REM_W-1:0]  rem_nxt;
      logic [cpct_pkg::ROOT_W-1:0] root_nxt;
      logic [cpct_pkg::REM_W-1:0]  t_hi;
      logic [cpct_pkg::REM_W-1:0]  rem_mid;
      logic [cpct_pkg::ROOT_W-1:0] root_mid;
      logic [cpct_pkg::REM_W-1:0]  t_lo;

      if (j == 0) begin : g_first
        assign rem_in  = cpct_pkg::REM_W'(in_sq);
        assign root_in = '0;
        assign vld_in  = in_vld;
      end else begin : g_next
        assign rem_in  = rem_r[j-1];
        assign root_in = root_r[j-1];
        assign vld_in  = vld_r[j-1];
      end

      // trial: (2*root + 2^k) * 2^k against the remainder
      always_comb begin
        t_hi = (cpct_pkg::REM_W'(root_in) << (KH + 1)) + (cpct_pkg::REM_W'(1) << (2 * KH));
        if (rem_in >= t_hi) begin
          rem_mid  = rem_in - t_hi;
          root_mid = root_in | (cpct_pkg::ROOT_W'(1) << KH);
        end else begin
          rem_mid  = rem_in;
          root_mid = root_in;
        end
        t_lo = (cpct_pkg::REM_W'(root_mid) << KH) + (cpct_pkg::REM_W'(1) << (2 * (KH - 1)));
        if (rem_mid >= t_lo) begin
          rem_nxt  = rem_mid - t_lo;
          root_nxt = root_mid | (cpct_pkg::ROOT_W'(1) << (KH - 1));
        end else begin
          rem_nxt  = rem_mid;
          root_nxt = root_mid;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (adv) begin
          vld_r[j] <= vld_in;
        end
        if (adv) begin
          rem_r[j]  <= rem_nxt;
          root_r[j] <= root_nxt;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[cpct_pkg::SQRT_STAGES-1];
  assign out_root = root_r[cpct_pkg::SQRT_STAGES-1];

endmodule

// ===== rtl/clarke_park_current_transform_unit.sv =====
// clarke/park current transform
// input channel: in_valid/in_stall carry three phase currents and an
// electrical angle; phase c of zero selects the two-sensor transform
// output channel: out_valid/out_stall carry d, q and the signed magnitude
// one transaction out for every transaction in, in the same order
// throughput: one transaction per clock unless the output stalls; the
// pipeline is 4 arithmetic stages, a radicand stage, an 11-stage square
// root (two root bits per stage) and an output register
// the whole pipeline advances together; while out_valid is high and
// out_stall is high nothing moves and in_stall is raised, no data is lost
// reset (synchronous, rst_n low) clears every valid bit; the sine table is
// constant and needs no set-up, so the block accepts in the first cycle
// after reset
module clarke_park_current_transform_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cpct_pkg::CUR_W-1:0]   in_phase_a,
  input  logic signed [cpct_pkg::CUR_W-1:0]   in_phase_b,
  input  logic signed [cpct_pkg::CUR_W-1:0]   in_phase_c,
  input  logic        [cpct_pkg::ANG_W-1:0]   in_elec_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cpct_pkg::OUT_W-1:0]   out_d_current,
  output logic signed [cpct_pkg::OUT_W-1:0]   out_q_current,
  output logic signed [cpct_pkg::OUT_W-1:0]   out_dc_current
);

  localparam int SIDE_DLY = cpct_pkg::SQRT_STAGES + 1;

  typedef struct packed {
    logic signed [cpct_pkg::OUT_W-1:0] d;
    logic signed [cpct_pkg::OUT_W-1:0] q;
    logic                              neg;
  } side_t;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: mean removal, table lookup
  logic signed [17:0] sum3;
  logic signed [33:0] m_prod;
  logic signed [33:0] a_sh;
  logic signed [33:0] b_sh;
  logic               v1_r;
  logic signed [33:0] A_r;
  logic signed [33:0] B_r;
  logic signed [17:0] st1_r;
  logic signed [17:0] ct1_r;
  logic               nz1_r;

  always_comb begin
    sum3 = 18'(in_phase_a) + 18'(in_phase_b) + 18'(in_phase_c);
    m_prod = 34'(sum3) * 34'(cpct_pkg::K_THIRD);
    a_sh = {{2{in_phase_a[15]}}, in_phase_a, 16'd0};
    b_sh = {{2{in_phase_b[15]}}, in_phase_b, 16'd0};
  end

  // stage 2: beta
  logic signed [52:0] beta_full;
  logic               v2_r;
  logic signed [33:0] alpha2_r;
  logic signed [34:0] beta2_r;
  logic signed [17:0] st2_r;
  logic signed [17:0] ct2_r;
  logic               nz2_r;

  assign beta_full = 53'(A_r) * 53'(cpct_pkg::K_INV_SQRT3)
                   + 53'(B_r) * 53'(cpct_pkg::K_TWO_INV_SQRT3) + 53'sd32768;

  // stage 3: rotation products, magnitude operands
  logic signed [52:0] p_ac_nxt;
  logic signed [52:0] p_bs_nxt;
  logic signed [52:0] p_bc_nxt;
  logic signed [52:0] p_as_nxt;
  logic signed [33:0] a_rnd;
  logic signed [34:0] b_rnd;
  logic               v3_r;
  logic signed [52:0] p_ac_r;
  logic signed [52:0] p_bs_r;
  logic signed [52:0] p_bc_r;
  logic signed [52:0] p_as_r;
  logic signed [22:0] a4_r;
  logic signed [22:0] b4_r;
  logic               nz3_r;

  always_comb begin
    p_ac_nxt = 53'(alpha2_r) * 53'(ct2_r);
    p_bs_nxt = 53'(beta2_r) * 53'(st2_r);
    p_bc_nxt = 53'(beta2_r) * 53'(ct2_r);
    p_as_nxt = 53'(alpha2_r) * 53'(st2_r);
    a_rnd = alpha2_r + 34'sd2048;
    b_rnd = beta2_r + 35'sd2048;
  end

  // stage 4: d/q rounding and saturation, squares
  logic signed [54:0] d_full;
  logic signed [54:0] q_raw;
  logic signed [54:0] q_full;
  logic signed [45:0] sqa_full;
  logic signed [45:0] sqb_full;
  logic               v4_r;
  side_t              side4_r;
  logic [42:0]        sqa_r;
  logic [42:0]        sqb_r;

  always_comb begin
    d_full = 55'(p_ac_r) + 55'(p_bs_r) + 55'sd2147483648;
    q_raw = 55'(p_bc_r) - 55'(p_as_r);
    q_full = q_raw + 55'sd2147483648;
    sqa_full = 46'(a4_r) * 46'(a4_r);
    sqb_full = 46'(b4_r) * 46'(b4_r);
  end

  // stage 5: radicand
  logic                          v5_r;
  logic [cpct_pkg::SQ_IN_W-1:0]  ssq_r;
  side_t                         side_r [0:SIDE_DLY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (adv) begin
      A_r   <= (in_phase_c != '0) ? a_sh - m_prod : a_sh;
      B_r   <= (in_phase_c != '0) ? b_sh - m_prod : b_sh;
      st1_r <= cpct_pkg::sine_q16(in_elec_angle);
      ct1_r <= cpct_pkg::sine_q16(in_elec_angle + 16'd16384);
      nz1_r <= (in_elec_angle != '0);

      alpha2_r <= A_r;
      beta2_r  <= beta_full[50:16];
      st2_r    <= st1_r;
      ct2_r    <= ct1_r;
      nz2_r    <= nz1_r;

      p_ac_r <= p_ac_nxt;
      p_bs_r <= p_bs_nxt;
      p_bc_r <= p_bc_nxt;
      p_as_r <= p_as_nxt;
      a4_r   <= {a_rnd[33], a_rnd[33:12]};
      b4_r   <= b_rnd[34:12];
      nz3_r  <= nz2_r;

      side4_r.d   <= cpct_pkg::sat_out(24'($signed(d_full[54:32])));
      side4_r.q   <= cpct_pkg::sat_out(24'($signed(q_full[54:32])));
      side4_r.neg <= nz3_r && (q_raw[54] || (q_raw == '0));
      sqa_r <= sqa_full[42:0];
      sqb_r <= sqb_full[42:0];

      ssq_r <= cpct_pkg::SQ_IN_W'(sqa_r) + cpct_pkg::SQ_IN_W'(sqb_r);
      side_r[0] <= side4_r;
      for (int i = 1; i < SIDE_DLY; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic                         sq_vld;
  logic [cpct_pkg::ROOT_W-1:0]  sq_root;

  cpct_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v5_r),
    .in_sq    (ssq_r),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  // output register
  logic [cpct_pkg::ROOT_W:0] mag_sum;
  logic signed [23:0]        dc_val;

  always_comb begin
    mag_sum = (cpct_pkg::ROOT_W+1)'(sq_root) + (cpct_pkg::ROOT_W+1)'(8);
    dc_val = 24'(mag_sum[cpct_pkg::ROOT_W:4]);
    if (side_r[SIDE_DLY-1].neg) dc_val = -dc_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sq_vld;
    end
    if (adv) begin
      out_d_current  <= side_r[SIDE_DLY-1].d;
      out_q_current  <= side_r[SIDE_DLY-1].q;
      out_dc_current <= cpct_pkg::sat_out(dc_val);
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised without a blocked output");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(out_d_current) && $stable(out_dc_current) && out_valid))
    else $error("pipeline moved during stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [cpct_pkg::CUR_W-1:0] in_phase_a = '0;
  logic signed [cpct_pkg::CUR_W-1:0] in_phase_b = '0;
  logic signed [cpct_pkg::CUR_W-1:0] in_phase_c = '0;
  logic [cpct_pkg::ANG_W-1:0] in_elec_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cpct_pkg::OUT_W-1:0] out_d_current;
  logic signed [cpct_pkg::OUT_W-1:0] out_q_current;
  logic signed [cpct_pkg::OUT_W-1:0] out_dc_current;

  typedef struct packed {
    logic signed [cpct_pkg::OUT_W-1:0] d;
    logic signed [cpct_pkg::OUT_W-1:0] q;
    logic signed [cpct_pkg::OUT_W-1:0] dc;
  } dq_result_t;

  dq_result_t expected_dq[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  longint quarter_sine[0:cpct_pkg::TBL_N];

  clarke_park_current_transform_unit uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint shr_round(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sat18(longint x);
    if (x > 131071) return 131071;
    if (x < -131072) return -131072;
    return x;
  endfunction

  // quarter-wave table built the same way as the rom: taylor series in q30
  task automatic build_quarter_sine();
    longint unsigned x, x2, term, n;
    longint sum, v;
    for (int k = 0; k <= cpct_pkg::TBL_N; k++) begin
      x = (64'd1686629713 * longint'(k)) >> cpct_pkg::SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n[0]) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + (1 << 13)) >>> 14;
      if (v > 65536) v = 65536;
      quarter_sine[k] = v;
    end
  endtask

  function automatic longint sine_of(logic [15:0] ang);
    int idx;
    longint v;
    idx = int'(ang[13:0]) >> (14 - cpct_pkg::SINE_TABLE_BITS);
    if (ang[14]) idx = cpct_pkg::TBL_N - idx;
    v = quarter_sine[idx];
    return ang[15] ? -v : v;
  endfunction

  function automatic longint isqrt(longint unsigned s);
    longint unsigned r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > s) bits >>= 2;
    while (bits != 0) begin
      if (s >= r + bits) begin
        s -= r + bits;
        r = (r >> 1) + bits;
      end else begin
        r >>= 1;
      end
      bits >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic dq_result_t transform_currents(logic signed [15:0] pa,
      logic signed [15:0] pb, logic signed [15:0] pc, logic [15:0] ang);
    longint a, b, c, alpha, beta, st, ct, d64, q64, a4, b4, mag, m;
    dq_result_t r;
    a = pa;
    b = pb;
    c = pc;
    alpha = a * 65536;
    beta = b * 65536;
    if (c != 0) begin
      m = 21845 * (a + b + c);
      alpha -= m;
      beta -= m;
    end
    beta = shr_round(37837 * alpha + 75674 * beta, 16);
    st = sine_of(ang);
    ct = sine_of(ang + 16'd16384);
    d64 = alpha * ct + beta * st;
    q64 = beta * ct - alpha * st;
    a4 = shr_round(alpha, 12);
    b4 = shr_round(beta, 12);
    mag = (isqrt(longint'(a4 * a4 + b4 * b4)) + 8) >>> 4;
    if (ang != 0 && !(q64 > 0)) mag = -mag;
    r.d = cpct_pkg::OUT_W'(sat18(shr_round(d64, 32)));
    r.q = cpct_pkg::OUT_W'(sat18(shr_round(q64, 32)));
    r.dc = cpct_pkg::OUT_W'(sat18(mag));
    return r;
  endfunction

  // called at a falling edge; valid stays high between back-to-back transactions
  task automatic send_currents(logic signed [15:0] pa, logic signed [15:0] pb,
      logic signed [15:0] pc, logic [15:0] ang);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_phase_a <= pa;
    in_phase_b <= pb;
    in_phase_c <= pc;
    in_elec_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dq.push_back(transform_currents(pa, pb, pc, ang));
    @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    dq_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dq.size() == 0) begin
        $error("unexpected transaction d=%0d q=%0d", out_d_current, out_q_current);
        errors++;
      end else begin
        e = expected_dq.pop_front();
        if (out_d_current !== e.d) begin
          $error("d_current expected %0d actual %0d", e.d, out_d_current);
          errors++;
        end
        if (out_q_current !== e.q) begin
          $error("q_current expected %0d actual %0d", e.q, out_q_current);
          errors++;
        end
        if (out_dc_current !== e.dc) begin
          $error("dc_current expected %0d actual %0d", e.dc, out_dc_current);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_extremes();
    send_currents(16'sh7fff, 16'sh7fff, 16'sd0, 16'd0);
    send_currents(16'sh8000, 16'sh8000, 16'sd0, 16'd8192);
    send_currents(16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff);
    send_currents(16'sh8000, 16'sh7fff, 16'sh8000, 16'd16384);
    send_currents(16'sh5555, 16'shaaaa, 16'sh5555, 16'haaaa);
    send_currents(16'shaaaa, 16'sh5555, 16'shaaaa, 16'h5555);
    send_currents(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd49152);
  endtask

  task automatic test_angles();
    // quadrant boundaries and zero angle (unsigned magnitude)
    send_currents(16'sd1000, -16'sd500, 16'sd0, 16'd0);
    send_currents(16'sd1000, -16'sd500, -16'sd500, 16'd0);
    send_currents(16'sd1000, -16'sd500, 16'sd0, 16'd16384);
    send_currents(16'sd1000, -16'sd500, 16'sd0, 16'd32768);
    send_currents(16'sd1000, -16'sd500, 16'sd0, 16'd49152);
    send_currents(-16'sd3000, 16'sd2000, 16'sd7, 16'd16383);
    send_currents(-16'sd3000, 16'sd2000, 16'sd7, 16'd32767);
  endtask

  task automatic test_zero_q();
    // q exactly zero with nonzero angle negates the magnitude
    send_currents(16'sd0, 16'sd0, 16'sd0, 16'd1234);
    send_currents(16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_currents(16'sd1, 16'sd1, 16'sd1, 16'd100);
    send_currents(-16'sd1, 16'sd0, 16'sd1, 16'd65535);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      logic signed [15:0] pa, pb, pc;
      logic [15:0] ang;
      pa = 16'($urandom);
      pb = 16'($urandom);
      pc = ($urandom_range(3) == 0) ? 16'sd0 : 16'($urandom);
      if ($urandom_range(3) == 0) begin
        pa = $signed(16'($urandom_range(400))) - 16'sd200;
        pb = $signed(16'($urandom_range(400))) - 16'sd200;
      end
      ang = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom);
      send_currents(pa, pb, pc, ang);
    end
  endtask

  initial begin
    build_quarter_sine();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 45;
    test_extremes();
    test_angles();
    test_zero_q();
    test_random(400);
    send_idle_pct = 45;
    recv_idle_pct = 21;
    test_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    in_valid <= 1'b0;
    while (expected_dq.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
